/* sv/ps2_mouse_packet_cursor_core_defines.svh */
// Assertion macros for the PS/2 mouse cursor core checker.
// No dependencies; taken in by the checker file only.
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define PMPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define PMPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pmpc_pkg.sv */
// Shared types and constants for the PS/2 mouse cursor core.
// No dependencies; imported by the framer, cursor, top level and bench.
`default_nettype none

package pmpc_pkg;

  // Header byte bits
  localparam int unsigned HdrLeft   = 0;
  localparam int unsigned HdrRight  = 1;
  localparam int unsigned HdrMiddle = 2;
  localparam int unsigned HdrSync   = 3;
  localparam int unsigned HdrXSign  = 4;
  localparam int unsigned HdrYSign  = 5;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgGridColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRows    = 2'd1;

  // Reset values
  localparam logic [7:0] GridColumnsRst = 8'd80;
  localparam logic [7:0] GridRowsRst    = 8'd25;
  localparam logic [7:0] PosXRst        = 8'd40;
  localparam logic [7:0] PosYRst        = 8'd12;

  // Completed packet handed from framer to cursor logic
  typedef struct packed {
    logic       done;
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

  // Result request payload
  typedef struct packed {
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic       left_pressed;
    logic       right_pressed;
    logic       middle_pressed;
  } res_t;

endpackage

`default_nettype wire

/* sv/pmpc_if.sv */
// Valid/ready channel interfaces: raw mouse byte in, cursor result out.
// No dependencies.
`default_nettype none

interface pmpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmpc_cursor_if;
  logic       valid;
  logic       ready;
  logic [7:0] cursor_x;
  logic [7:0] cursor_y;
  logic       left_pressed;
  logic       right_pressed;
  logic       middle_pressed;

  modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                  output right_pressed, output middle_pressed, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                  input right_pressed, input middle_pressed, output ready);
endinterface

`default_nettype wire

/* sv/pmpc_framer.sv */
// Packet framer: tracks byte phase and holds header and X bytes.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_framer
  import pmpc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  output pkt_t            pkt_o
);

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_XBYTE = 2'd1,
    PH_YBYTE = 2'd2
  } phase_e;

  phase_e     phase_q;
  logic [7:0] header_q;
  logic [7:0] x_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD;
      header_q <= 8'd0;
      x_byte_q <= 8'd0;
    end else if (accept_i) begin
      unique case (phase_q)
        PH_HEAD: begin
          // drop bytes without the sync bit
          if (byte_i[HdrSync]) begin
            header_q <= byte_i;
            phase_q  <= PH_XBYTE;
          end
        end
        PH_XBYTE: begin
          x_byte_q <= byte_i;
          phase_q  <= PH_YBYTE;
        end
        PH_YBYTE: phase_q <= PH_HEAD;
        default: begin
          if (byte_i[HdrSync]) begin
            header_q <= byte_i;
            phase_q  <= PH_XBYTE;
          end else begin
            phase_q <= PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    pkt_o.done   = accept_i && (phase_q == PH_YBYTE);
    pkt_o.header = header_q;
    pkt_o.x_byte = x_byte_q;
    pkt_o.y_byte = byte_i;
  end

endmodule

`default_nettype wire

/* sv/pmpc_cursor.sv */
// Cursor update: grid registers, delta halving, clamp, result register.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_cursor
  import pmpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire pkt_t               pkt_i,
  input  wire logic               res_ready_i,
  output logic                    res_valid_o,
  output res_t                    res_o
);

  logic [7:0] cols_q, rows_q;
  logic [7:0] pos_x_q, pos_y_q;
  logic [7:0] pos_x_d, pos_y_d;
  logic       res_valid_q;
  res_t       res_q;

  // 9-bit delta halved toward zero: add one when negative, then shift.
  function automatic logic signed [7:0] halve9(input logic sign, input logic [7:0] low);
    logic signed [8:0] v;
    v = $signed({sign, low}) + $signed({8'd0, sign});
    return v[8:1];
  endfunction

  function automatic logic [7:0] clamp_axis(input logic signed [9:0] v,
                                            input logic [7:0] size);
    logic [7:0] top;
    top = (size == 8'd0) ? 8'd0 : size - 8'd1;
    if (v < 0) begin
      return 8'd0;
    end else if (v > $signed({2'b00, top})) begin
      return top;
    end else begin
      return v[7:0];
    end
  endfunction

  logic signed [7:0] dx, dy;
  logic signed [9:0] sum_x, sum_y;

  always_comb begin
    dx      = halve9(pkt_i.header[HdrXSign], pkt_i.x_byte);
    dy      = halve9(pkt_i.header[HdrYSign], pkt_i.y_byte);
    sum_x   = $signed({2'b00, pos_x_q}) + $signed({{2{dx[7]}}, dx});
    sum_y   = $signed({2'b00, pos_y_q}) - $signed({{2{dy[7]}}, dy});
    pos_x_d = clamp_axis(sum_x, cols_q);
    pos_y_d = clamp_axis(sum_y, rows_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= GridColumnsRst;
      rows_q      <= GridRowsRst;
      pos_x_q     <= PosXRst;
      pos_y_q     <= PosYRst;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgGridColumns) cols_q <= cfg_data_i;
        if (cfg_idx_i == CfgGridRows)    rows_q <= cfg_data_i;
      end
      if (pkt_i.done) begin
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.done) begin
      res_q.cursor_x       <= pos_x_d;
      res_q.cursor_y       <= pos_y_d;
      res_q.left_pressed   <= pkt_i.header[HdrLeft];
      res_q.right_pressed  <= pkt_i.header[HdrRight];
      res_q.middle_pressed <= pkt_i.header[HdrMiddle];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* sv/ps2_mouse_packet_cursor_core.sv */
// Top level of the PS/2 mouse cursor core: framer plus cursor update.
// Depends on pmpc_pkg, pmpc_if, pmpc_framer and pmpc_cursor.
`default_nettype none

// PS/2 mouse packet decoder driving a clamped grid cursor. Raw bytes arrive
// on in_if, one per request; a header byte must have bit 3 set or it is
// dropped. After the third byte of a packet the halved X delta is added and
// the halved Y delta subtracted, both clamped to grid_columns-1 and
// grid_rows-1 (a size of zero clamps to 0), and one result request carrying
// position and the three buttons appears on out_if the next cycle. A byte
// is taken every cycle: in_if.ready only drops while a finished result
// sits in the output register and out_if.ready is low. The single output
// register is the only buffering. Position resets to 40,12 and the grid to
// 80 by 25. Write the grid through cfg_we_i/cfg_idx_i/cfg_data_i (index
// 0 columns, 1 rows) only when idle; a new grid takes effect on the next
// packet.

module ps2_mouse_packet_cursor_core
  import pmpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  pmpc_byte_if.sink               in_if,
  pmpc_cursor_if.source           out_if
);

  logic accept;
  logic res_valid;
  pkt_t pkt;
  res_t res;

  // Free when the result slot is empty or being drained this cycle.
  assign in_if.ready = !res_valid || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  pmpc_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_if.rx_byte),
    .pkt_o    (pkt)
  );

  pmpc_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pkt_i       (pkt),
    .res_ready_i (out_if.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_if.valid          = res_valid;
  assign out_if.cursor_x       = res.cursor_x;
  assign out_if.cursor_y       = res.cursor_y;
  assign out_if.left_pressed   = res.left_pressed;
  assign out_if.right_pressed  = res.right_pressed;
  assign out_if.middle_pressed = res.middle_pressed;

endmodule

`default_nettype wire

/* sv/pmpc_checker.sv */
// Port-level checker for the PS/2 mouse cursor core, bound to the top.
// Depends on ps2_mouse_packet_cursor_core_defines.svh.
`default_nettype none

`include "ps2_mouse_packet_cursor_core_defines.svh"

module pmpc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] cursor_x_i,
  input wire logic [7:0] cursor_y_i
);

  `PMPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(cursor_x_i) && $stable(cursor_y_i), "stalled result changed")
  `PMPC_ASSERT_NOW(a_stall_blocks_in, clk_i, rst_ni, out_valid_i && !out_ready_i,
    !in_ready_i, "byte taken while result slot full")
  `PMPC_ASSERT_NOW(a_rise_needs_byte, clk_i, rst_ni, $rose(out_valid_i),
    $past(in_valid_i && in_ready_i), "result without accepted byte")
  `PMPC_ASSERT_NOW(a_refill_needs_byte, clk_i, rst_ni,
    out_valid_i && $past(out_valid_i && out_ready_i),
    $past(in_valid_i && in_ready_i), "new result without accepted byte")

endmodule

bind ps2_mouse_packet_cursor_core pmpc_checker u_pmpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .cursor_x_i  (out_if.cursor_x),
  .cursor_y_i  (out_if.cursor_y)
);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for ps2_mouse_packet_cursor_core: byte requests in, cursor requests out.
// Depends on pmpc_pkg, pmpc_if and the core; predicts each cursor request and checks it in order.

module tb_top;
  import pmpc_pkg::*;

  // Indexes past the two grid registers; the core must ignore writes to them
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  localparam int unsigned QuietLimit  = 1000; // cycles with no handshake at all
  localparam int unsigned DrainCycles = 4;    // single-register pipe, plus margin

  // Framing phase of the predictor
  typedef enum logic [1:0] {
    AwaitHeader,
    AwaitX,
    AwaitY
  } frame_phase_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [7:0]          cfg_data;

  pmpc_byte_if   byte_req ();
  pmpc_cursor_if cursor_req ();

  ps2_mouse_packet_cursor_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (byte_req),
    .out_if     (cursor_req)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the grid and of the framer / cursor registers
  // ---------------------------------------------------------------------------
  logic [7:0]   grid_cols_m;
  logic [7:0]   grid_rows_m;
  frame_phase_e frame_phase;
  logic [7:0]   held_header;
  logic [7:0]   held_x;
  logic [7:0]   cur_x;
  logic [7:0]   cur_y;

  res_t cursor_expected [$];

  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          idle_on;
  int unsigned ready_hold;

  // Clamp one axis to 0 .. size-1; a size of zero behaves like one
  function automatic logic [7:0] fit_to_grid(input int v, input logic [7:0] size);
    int top;
    top = (size == 8'd0) ? 0 : int'(size) - 1;
    if (v < 0) return 8'd0;
    if (v > top) return 8'(top);
    return 8'(v);
  endfunction

  // 9-bit two's complement delta, halved towards zero
  function automatic int half_delta(input logic [7:0] low, input logic neg);
    int v;
    v = int'(low);
    if (neg) v -= 256;
    return v / 2;
  endfunction

  // Advance the predictor by one accepted byte; queue a cursor request on
  // the third byte of a packet
  task automatic predict_cursor(input logic [7:0] b);
    res_t r;
    int   dx, dy;
    case (frame_phase)
      AwaitX: begin
        held_x      = b;
        frame_phase = AwaitY;
      end
      AwaitY: begin
        frame_phase = AwaitHeader;
        dx    = half_delta(held_x, held_header[HdrXSign]);
        dy    = half_delta(b, held_header[HdrYSign]);
        cur_x = fit_to_grid(int'(cur_x) + dx, grid_cols_m);
        cur_y = fit_to_grid(int'(cur_y) - dy, grid_rows_m); // screen y grows downward
        r.cursor_x       = cur_x;
        r.cursor_y       = cur_y;
        r.left_pressed   = held_header[HdrLeft];
        r.right_pressed  = held_header[HdrRight];
        r.middle_pressed = held_header[HdrMiddle];
        cursor_expected.push_back(r);
      end
      default: begin
        // header slot: only a byte with the sync bit opens a packet
        frame_phase = AwaitHeader;
        if (b[HdrSync]) begin
          held_header = b;
          frame_phase = AwaitX;
        end
      end
    endcase
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, driven at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!idle_on) begin
      ready_hold       = 0;
      cursor_req.ready = 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      cursor_req.ready = ($urandom_range(0, 3) != 0);
      ready_hold       = idle_len();
    end
  end

  task automatic flag_field(input string name, input logic [7:0] exp_v,
                            input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Checker: every cursor request is matched against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && cursor_req.valid && cursor_req.ready) begin
      if (cursor_expected.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected cursor request, expected none, got x=%0d y=%0d",
                 $time, cursor_req.cursor_x, cursor_req.cursor_y);
      end else begin
        want = cursor_expected.pop_front();
        flag_field("cursor_x", want.cursor_x, cursor_req.cursor_x);
        flag_field("cursor_y", want.cursor_y, cursor_req.cursor_y);
        flag_field("left_pressed", 8'(want.left_pressed), 8'(cursor_req.left_pressed));
        flag_field("right_pressed", 8'(want.right_pressed), 8'(cursor_req.right_pressed));
        flag_field("middle_pressed", 8'(want.middle_pressed),
                   8'(cursor_req.middle_pressed));
      end
    end
  end

  // Watchdog: too long with no handshake on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (byte_req.valid && byte_req.ready) ||
        (cursor_req.valid && cursor_req.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One byte request; valid stays up after acceptance so back-to-back
  // bytes need no extra assignment, the next call or a drain decides
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      byte_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_req.valid   = 1'b1;
    byte_req.rx_byte = b;
    do @(posedge clk); while (!byte_req.ready);
    predict_cursor(b);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Drop valid, let all predicted requests arrive, then a few quiet cycles
  task automatic wait_drained();
    @(negedge clk);
    byte_req.valid = 1'b0;
    while (cursor_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write, only ever issued with the core idle
  task automatic write_grid_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CfgGridColumns: grid_cols_m = val;
      CfgGridRows:    grid_rows_m = val;
      default: ;      // spare index, no effect
    endcase
  endtask

  // Delta with sign in bit 8: half the time small, else anything
  function automatic logic [8:0] rand_delta();
    int unsigned k;
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, 12);
      return ($urandom_range(0, 1)) ? 9'(512 - k) : 9'(k);
    end
    return 9'($urandom);
  endfunction

  task automatic send_random_packet();
    logic [8:0] dx, dy;
    logic [7:0] hdr;
    dx  = rand_delta();
    dy  = rand_delta();
    hdr = 8'($urandom);
    hdr[HdrSync]  = 1'b1;
    hdr[HdrXSign] = dx[8];
    hdr[HdrYSign] = dy[8];
    send_packet(hdr, dx[7:0], dy[7:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default 80 by 25 grid from the 40,12 reset position: dropped headers,
  // extreme deltas, truncation of -1, overflow bits
  task automatic test_packet_fields();
    send_byte(8'h00);                     // no sync bit: dropped
    send_byte(8'hF7);                     // every bit but sync: dropped
    send_packet(8'h0F, 8'hFF, 8'h00);     // all buttons, x +127 to the right edge
    send_packet(8'h38, 8'h00, 8'h00);     // both deltas -256: x to 0, y to bottom
    send_packet(8'h38, 8'hFF, 8'hFF);     // -1 halves to 0: no move
    send_packet(8'hFF, 8'h80, 8'h7F);     // overflow bits set, both signs
  endtask

  // Smallest grids, including a size of zero
  task automatic test_grid_extremes();
    write_grid_reg(CfgGridColumns, 8'd1);
    write_grid_reg(CfgGridRows, 8'd1);
    send_packet(8'h0F, 8'h10, 8'hF0);
    write_grid_reg(CfgGridColumns, 8'd0);
    write_grid_reg(CfgGridRows, 8'd0);
    send_packet(8'h28, 8'h7F, 8'h00);
  endtask

  // Move far out on the full grid, shrink it, and let the next packet clamp
  task automatic test_grid_shrink();
    write_grid_reg(CfgGridColumns, 8'd255);
    write_grid_reg(CfgGridRows, 8'd255);
    send_packet(8'h28, 8'hFF, 8'h00);
    send_packet(8'h28, 8'hFF, 8'h00);
    write_grid_reg(CfgGridColumns, 8'd10);
    write_grid_reg(CfgGridRows, 8'd5);
    send_packet(8'h08, 8'h00, 8'h00);
  endtask

  // Writes beyond the two grid registers leave the grid alone
  task automatic test_spare_index();
    write_grid_reg(CfgIdxSpareLo, 8'd200);
    write_grid_reg(CfgIdxSpareHi, 8'd3);
    send_packet(8'h18, 8'h7F, 8'h81);
  endtask

  // Mostly well-formed packets with random content, some noise and
  // truncated packets that knock the framing out of step
  task automatic test_random_traffic();
    logic [7:0]  cols, rows, b;
    int unsigned sent, pick;
    for (int round = 0; round < 6; round++) begin
      idle_on = (round != 2);             // one stretch at full rate
      case (round)
        0: begin cols = 8'd255; rows = 8'd255; end
        2: begin cols = 8'd1;   rows = 8'd255; end
        3: begin cols = 8'd255; rows = 8'd1;   end
        4: begin cols = 8'($urandom_range(2, 16)); rows = 8'($urandom_range(2, 16)); end
        default: begin
          cols = 8'($urandom_range(1, 255));
          rows = 8'($urandom_range(1, 255));
        end
      endcase
      write_grid_reg(CfgGridColumns, cols);
      write_grid_reg(CfgGridRows, rows);
      sent = 0;
      while (sent < 215) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          send_random_packet();
          sent += 3;
        end else if (pick < 18) begin
          b = 8'($urandom);
          if ($urandom_range(0, 1)) b[HdrSync] = 1'b0;
          send_byte(b);
          sent += 1;
        end else begin
          b = 8'($urandom);
          b[HdrSync] = 1'b1;
          send_byte(b);                   // header and x only
          send_byte(8'($urandom));
          sent += 2;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgGridColumns;
    cfg_data         = 8'd0;
    byte_req.valid   = 1'b0;
    byte_req.rx_byte = 8'd0;
    cursor_req.ready = 1'b0;
    idle_on          = 1'b1;
    ready_hold       = 0;
    fail_count       = 0;
    quiet_cycles     = 0;

    grid_cols_m = GridColumnsRst;
    grid_rows_m = GridRowsRst;
    frame_phase = AwaitHeader;
    held_header = 8'd0;
    held_x      = 8'd0;
    cur_x       = PosXRst;
    cur_y       = PosYRst;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_packet_fields();
    test_grid_extremes();
    test_grid_shrink();
    test_spare_index();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
